FILE: design/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ENC  = 2'd1;
	localparam logic [1:0] CMD_DEC  = 2'd2;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] blk_t;

	function automatic byte_t xt(input byte_t a);
		xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic byte_t gmul(input byte_t a, input byte_t b);
		byte_t p;
		byte_t x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p = p ^ x;
			x = xt(x);
		end
		gmul = p;
	endfunction

	function automatic byte_t ginv(input byte_t a);
		byte_t r;
		byte_t b;
		r = 8'h01;
		b = a;
		for (int i = 0; i < 8; i++) begin
			if (i != 0) r = gmul(r, b);
			b = gmul(b, b);
		end
		ginv = r;
	endfunction

	function automatic byte_t rl(input byte_t x, input int n);
		rl = byte_t'((x << n) | (x >> (8 - n)));
	endfunction

	function automatic byte_t fwd_box(input byte_t x);
		byte_t v;
		v = ginv(x);
		fwd_box = v ^ rl(v, 1) ^ rl(v, 2) ^ rl(v, 3) ^ rl(v, 4) ^ 8'h63;
	endfunction

	function automatic byte_t rev_box(input byte_t x);
		rev_box = ginv(rl(x, 1) ^ rl(x, 3) ^ rl(x, 6) ^ 8'h05);
	endfunction

	// constant lookup tables built at elaboration
	typedef byte_t sbox_t [256];
	function automatic sbox_t mk_box(input logic inv);
		sbox_t t;
		for (int i = 0; i < 256; i++)
			t[i] = inv ? rev_box(byte_t'(i)) : fwd_box(byte_t'(i));
		mk_box = t;
	endfunction
	localparam sbox_t FWD_LUT = mk_box(1'b0);
	localparam sbox_t REV_LUT = mk_box(1'b1);

	function automatic blk_t sub_shift(input blk_t s, input logic inv);
		blk_t o;
		int src;
		for (int r = 0; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				src = inv ? ((c + 4 - r) & 3) : ((c + r) & 3);
				o[(c*4+r)*8 +: 8] = inv ? REV_LUT[s[(src*4+r)*8 +: 8]]
				                        : FWD_LUT[s[(src*4+r)*8 +: 8]];
			end
		sub_shift = o;
	endfunction

	function automatic blk_t mix(input blk_t s, input logic inv);
		blk_t o;
		byte_t m [4];
		byte_t acc;
		if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
		else m = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int k = 0; k < 4; k++)
					acc = acc ^ gmul(m[(k - r + 4) & 3], s[(c*4+k)*8 +: 8]);
				o[(c*4+r)*8 +: 8] = acc;
			end
		mix = o;
	endfunction
endpackage

FILE: design/aes128_block_cipher.sv
`timescale 1ns / 1ps
// channel  signals                               direction
// in       in_valid/in_stall cmd word_index data_word   into block
// out      out_valid/out_stall out_word out_half last   out of block
// the high half's accept cycle applies the first key step, then one round per
// cycle; the low output half is valid once the rounds are done
// key words and low halves leave the block idle; in_stall is high from the high half
// until both output requests have gone
// out_stall holds the current output half; arst_n clears control and data registers, not the keys
module aes128_block_cipher #(
	parameter int ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [4:0]  word_index,
	input  logic [63:0] data_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_word,
	output logic        out_half,
	output logic        last
);
	import aes_pkg::*;

	localparam int KW = 2 * (ROUNDS + 1);
	localparam int RB = $clog2(ROUNDS + 1);
	localparam int KB = $clog2(KW);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_OUT0 = 2'd2;
	localparam logic [1:0] ST_OUT1 = 2'd3;

	logic [127:0] key_mem [ROUNDS + 1];
	logic [63:0]  low_q;
	logic [127:0] blk_q;
	logic [1:0]   state_q;
	logic [RB-1:0] rnd_q;
	logic         dec_q;
	logic         acc;
	logic [127:0] rk;
	logic [127:0] nxt;
	logic [127:0] ss;

	assign in_stall = (state_q != ST_IDLE);
	assign acc = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT0) || (state_q == ST_OUT1);
	assign out_half = (state_q == ST_OUT1);
	assign last = out_half;
	assign out_word = out_half ? blk_q[127:64] : blk_q[63:0];

	// key store as one 128-bit row per round, written a half at a time
	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_LOAD && word_index < 5'(KW))
			if (word_index[0]) key_mem[word_index[KB-1:1]][127:64] <= data_word;
			else key_mem[word_index[KB-1:1]][63:0] <= data_word;
	end

	assign rk = key_mem[rnd_q];

	// step rnd_q is the round key applied this cycle
	always_comb begin
		ss = 128'd0;
		if (!dec_q) begin
			ss = sub_shift(blk_q, 1'b0);
			if (rnd_q == RB'(ROUNDS)) nxt = ss ^ rk;
			else nxt = mix(ss, 1'b0) ^ rk;
		end else begin
			if (rnd_q == RB'(0)) nxt = blk_q ^ rk;
			else nxt = sub_shift(mix(blk_q ^ rk, 1'b1), 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			low_q   <= 64'd0;
			blk_q   <= 128'd0;
			rnd_q   <= '0;
			dec_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && (cmd == CMD_ENC || cmd == CMD_DEC)) begin
						if (word_index == 5'd0) begin
							low_q <= data_word;
						end else begin
							dec_q   <= (cmd == CMD_DEC);
							state_q <= ST_RUN;
							if (cmd == CMD_DEC) begin
								// first inverse step: last key, inverse shift and sub
								rnd_q <= RB'(ROUNDS - 1);
								blk_q <= sub_shift({data_word, low_q} ^ key_mem[ROUNDS], 1'b1);
							end else begin
								rnd_q <= RB'(1);
								blk_q <= {data_word, low_q} ^ key_mem[0];
							end
						end
					end
				end
				ST_RUN: begin
					blk_q <= nxt;
					if (dec_q) begin
						if (rnd_q == RB'(0)) state_q <= ST_OUT0;
						else rnd_q <= rnd_q - RB'(1);
					end else begin
						if (rnd_q == RB'(ROUNDS)) state_q <= ST_OUT0;
						else rnd_q <= rnd_q + RB'(1);
					end
				end
				ST_OUT0: if (!out_stall) state_q <= ST_OUT1;
				ST_OUT1: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
